// ===== rtl/bfiq_pkg.sv =====
package bfiq_pkg;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_BYTES = 2'd0;
    localparam logic [1:0] CFG_PROBE_COUNT  = 2'd1;

    // register widths and reset values
    localparam int FILTER_BYTES_W = 13;
    localparam int PROBE_COUNT_W  = 8;
    localparam logic [FILTER_BYTES_W-1:0] FILTER_BYTES_RST = 13'd4096;
    localparam logic [PROBE_COUNT_W-1:0]  PROBE_COUNT_RST  = 8'd6;

    // fixed limits of the filter
    localparam int MIN_BYTES  = 8;
    localparam int MAX_PROBES = 30;
    localparam int PROBE_W    = 5;
    localparam int HASH_W     = 32;
    localparam int HASH_CNT_W = 5;

    // rotate right by 17 gives the probe step
    function automatic logic [HASH_W-1:0] probe_step(input logic [HASH_W-1:0] key);
        probe_step = {key[16:0], key[31:17]};
    endfunction

endpackage

// ===== rtl/bfiq_ram.sv =====
module bfiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== rtl/bfiq_cond_sub.sv =====
module bfiq_cond_sub #(
    parameter int W = 16
) (
    input  logic [W:0]   a,
    input  logic [W-1:0] d,
    output logic [W-1:0] y
);

    logic [W:0] diff;

    // subtract divisor once when the value reaches it
    always_comb
    begin
        diff = a - {1'b0, d};
        if (a >= {1'b0, d})
        begin
            y = diff[W-1:0];
        end
        else
        begin
            y = a[W-1:0];
        end
    end

endmodule

// ===== rtl/bloom_filter_insert_query.sv =====
// bloom filter, insert and query by double hashing over a byte-wide bit store
// insert or query: per probe a bit-serial remainder, a memory read, then a test or write back,
// 1 to 30 probes, a query stops at its first clear bit
// clear: one store byte per cycle over all MAX_BYTES bytes; unused action or a query of 0 or
// over 30 probes: no busy state; done strobes in the next cycle, which can take a new start
// reset: the same clearing pass runs with busy high and no done strobe
module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int MAX_BYTES = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                action,
    input  logic [HASH_W-1:0]         key_hash,
    output logic                      done,
    output logic                      may_match,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [FILTER_BYTES_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_BYTES);
    localparam int BW = $clog2(MAX_BYTES * 8 + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_EX   = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic                      clr_report_reg, clr_report_next;
    logic                      done_reg, done_next;
    logic                      match_reg, match_next;
    logic                      query_reg, query_next;
    logic [PROBE_W-1:0]        k_reg, k_next;
    logic [PROBE_W-1:0]        idx_reg, idx_next;
    logic [HASH_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [HASH_W-1:0]         dvd_reg, dvd_next;
    logic [HASH_W-1:0]         hash_reg, hash_next;
    logic [HASH_W-1:0]         step_reg, step_next;
    logic [BW-1:0]             rem_reg, rem_next;
    logic [BW-1:0]             pos_reg, pos_next;
    logic [FILTER_BYTES_W-1:0] filter_bytes_reg;
    logic [PROBE_COUNT_W-1:0]  probe_count_reg;

    logic [31:0]   used_bytes;
    logic [31:0]   bits_wide;
    logic [BW-1:0] bits;
    logic [BW:0]   unit_a;
    logic [BW-1:0] unit_y;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    bit_mask;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bytes_reg <= FILTER_BYTES_RST;
            probe_count_reg  <= PROBE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_BYTES: filter_bytes_reg <= cfg_data;
                CFG_PROBE_COUNT:  probe_count_reg  <= cfg_data[PROBE_COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // bit count of the filter in use
    always_comb
    begin
        used_bytes = {{(32 - FILTER_BYTES_W){1'b0}}, filter_bytes_reg};
        if (used_bytes < 32'(MIN_BYTES))
        begin
            used_bytes = 32'(MIN_BYTES);
        end
        if (used_bytes > 32'(MAX_BYTES))
        begin
            used_bytes = 32'(MAX_BYTES);
        end
        bits_wide = {used_bytes[28:0], 3'b000};
        bits      = bits_wide[BW-1:0];
    end

    // shared compare and subtract: one remainder bit per cycle
    assign unit_a = {rem_reg, dvd_reg[HASH_W-1]};

    bfiq_cond_sub #(
        .W (BW)
    ) u_cond_sub (
        .a (unit_a),
        .d (bits),
        .y (unit_y)
    );

    // filter store
    assign bit_mask = 8'd1 << pos_reg[2:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = AW'(pos_reg >> 3);
        ram_wdata = ram_rdata | bit_mask;
        if (state_reg == ST_CLR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = 8'd0;
        end
        else if (state_reg == ST_EX && !query_reg)
        begin
            ram_we = 1'b1;
        end
    end

    bfiq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        done_next       = 1'b0;
        match_next      = match_reg;
        query_next      = query_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        bit_cnt_next    = bit_cnt_reg;
        dvd_next        = dvd_reg;
        hash_next       = hash_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    dvd_next     = key_hash;
                    hash_next    = key_hash;
                    step_next    = probe_step(key_hash);
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    idx_next     = '0;
                    case (action)
                        ACT_CLEAR:
                        begin
                            state_next      = ST_CLR;
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            state_next = ST_DIV;
                            query_next = 1'b0;
                            if (probe_count_reg == '0)
                            begin
                                k_next = PROBE_W'(1);
                            end
                            else if (probe_count_reg > PROBE_COUNT_W'(MAX_PROBES))
                            begin
                                k_next = PROBE_W'(MAX_PROBES);
                            end
                            else
                            begin
                                k_next = probe_count_reg[PROBE_W-1:0];
                            end
                        end
                        ACT_QUERY:
                        begin
                            query_next = 1'b1;
                            k_next     = probe_count_reg[PROBE_W-1:0];
                            if (probe_count_reg == '0 ||
                                probe_count_reg > PROBE_COUNT_W'(MAX_PROBES))
                            begin
                                done_next  = 1'b1;
                                match_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            match_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(MAX_BYTES - 1))
                begin
                    state_next      = ST_IDLE;
                    done_next       = clr_report_reg;
                    match_next      = 1'b0;
                    clr_report_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                // one remainder bit per cycle of the probe hash
                rem_next     = unit_y;
                dvd_next     = {dvd_reg[HASH_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == '1)
                begin
                    rem_next   = '0;
                    pos_next   = unit_y;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                // insert writes back here, query tests the bit
                if (query_reg && (ram_rdata & bit_mask) == 8'd0)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    match_next = 1'b0;
                end
                else if (idx_reg == k_reg - 1'b1)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    match_next = query_reg;
                end
                else
                begin
                    // next probe hash wraps at 32 bits, then its remainder again
                    idx_next   = idx_reg + 1'b1;
                    hash_next  = hash_reg + step_reg;
                    dvd_next   = hash_reg + step_reg;
                    state_next = ST_DIV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            bit_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            bit_cnt_reg    <= bit_cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        query_reg <= query_next;
        k_reg     <= k_next;
        dvd_reg   <= dvd_next;
        hash_reg  <= hash_next;
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        pos_reg   <= pos_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign may_match = match_reg;

endmodule
